FILE: hw/rtl/dst_pkg.sv
// ----------------------------------------------------------------------------
// dst_pkg: shared definitions for the descriptor slot table
// table geometry, free-slot summary sizing, descriptor packing and reset tables
// ----------------------------------------------------------------------------
`default_nettype none

package dst_pkg;

  localparam int unsigned TABLE_ENTRIES  = 8192;
  localparam int unsigned RESERVED_SLOTS = 5;
  localparam int unsigned FLAT_COUNT     = 5;

  localparam int unsigned IDX_W       = $clog2(TABLE_ENTRIES);
  localparam int unsigned MAP_W       = (TABLE_ENTRIES / 2 < 64) ? TABLE_ENTRIES / 2 : 64;
  localparam int unsigned MAP_WORDS   = TABLE_ENTRIES / MAP_W;
  localparam int unsigned WORD_W      = $clog2(MAP_WORDS);
  localparam int unsigned BIT_W       = $clog2(MAP_W);

  localparam int unsigned SCAN_W      = 16;
  localparam int unsigned POS_W       = $clog2(SCAN_W);
  localparam int unsigned WORD_SLICES = (MAP_W + SCAN_W - 1) / SCAN_W;
  localparam int unsigned SLICE_W     = (WORD_SLICES > 1) ? $clog2(WORD_SLICES) : 1;
  localparam int unsigned GROUPS      = (MAP_WORDS + SCAN_W - 1) / SCAN_W;
  localparam int unsigned GROUP_W     = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  localparam int unsigned FRESH_N = (RESERVED_SLOTS > FLAT_COUNT) ? RESERVED_SLOTS : FLAT_COUNT;
  localparam int unsigned FRESH_W = $clog2(FRESH_N);

  localparam int unsigned SEL_IDX_W = 13;
  localparam int unsigned LIMIT_W   = 20;

  localparam logic [7:0]         TSS_ACCESS  = 8'h89;
  localparam logic [3:0]         TSS_FLAGS   = 4'h0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd103;

  typedef enum logic [1:0] {
    KIND_INSTALL   = 2'd0,
    KIND_UNINSTALL = 2'd1,
    KIND_LOOKUP    = 2'd2,
    KIND_NONE      = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GROUP,
    ST_WORD,
    ST_BITS,
    ST_READ,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
  } ffz_res_t;

  function automatic logic [63:0] pack_tss(logic [31:0] base, logic [LIMIT_W-1:0] limit);
    return {base[31:24], TSS_FLAGS, limit[19:16], TSS_ACCESS, base[23:0], limit[15:0]};
  endfunction

  function automatic logic [63:0] flat_word(logic [FRESH_W-1:0] slot);
    logic [63:0] w;
    unique case (slot)
      FRESH_W'(1): w = 64'h00CF_9A00_0000_FFFF;
      FRESH_W'(2): w = 64'h00CF_9200_0000_FFFF;
      FRESH_W'(3): w = 64'h00CF_F800_0000_FFFF;
      FRESH_W'(4): w = 64'h00CF_F200_0000_FFFF;
      default:     w = 64'h0;
    endcase
    return w;
  endfunction

  function automatic logic [MAP_W-1:0] reset_word(logic [WORD_W-1:0] w);
    logic [MAP_W-1:0] r;
    for (int unsigned b = 0; b < MAP_W; b++) begin
      r[b] = ((int'(w) * MAP_W + b) < RESERVED_SLOTS);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/dst_if.sv
// ----------------------------------------------------------------------------
// dst_if: request and response channels of the descriptor slot table
// valid/ready channels, one beat per request and one per response
// ----------------------------------------------------------------------------
`default_nettype none

interface dst_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] base_address;
  logic [15:0] selector;

  modport source (output valid, output kind, output base_address, output selector,
                  input ready);
  modport sink   (input valid, input kind, input base_address, input selector,
                  output ready);
endinterface

interface dst_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [15:0] new_selector;
  logic [63:0] descriptor_word;

  modport source (output valid, output status, output new_selector, output descriptor_word,
                  input ready);
  modport sink   (input valid, input status, input new_selector, input descriptor_word,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/dst_ffz.sv
// ----------------------------------------------------------------------------
// dst_ffz: find-first-zero unit
// returns the lowest clear bit of a 16-bit slice, shared by every search step
// ----------------------------------------------------------------------------
`default_nettype none

module dst_ffz (
  input  logic [dst_pkg::SCAN_W-1:0] bits_i,
  output dst_pkg::ffz_res_t          res_o
);

  always_comb begin
    res_o.found = 1'b0;
    res_o.pos   = '0;
    for (int i = dst_pkg::SCAN_W - 1; i >= 0; i--) begin
      if (!bits_i[i]) begin
        res_o.found = 1'b1;
        res_o.pos   = dst_pkg::POS_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/descriptor_slot_table.sv
// ----------------------------------------------------------------------------
// descriptor_slot_table: x86 segment descriptor table with slot allocator
// used-slot bitmap in words with per-word full flags and group summary,
// searched by one shared find-first-zero unit under a small sequencer
// ----------------------------------------------------------------------------
// sequence: install walks group summary, word flags and bitmap slices in the
//   finder (a full table ends after the summary); uninstall and lookup read the
//   bitmap and table unless the selector is out of range; those and unknown kinds
//   go straight to done; one request at a time (ready only in idle)
// reset: no clearing pass; bitmap words carry valid bits, reserved flat
//   descriptors come from a constant table until their slot is written
`default_nettype none

module descriptor_slot_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  dst_in_if.sink                         in_i,
  dst_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [dst_pkg::LIMIT_W-1:0]    cfg_wdata_i
);

  localparam int unsigned MAP_W   = dst_pkg::MAP_W;
  localparam int unsigned WORD_W  = dst_pkg::WORD_W;
  localparam int unsigned BIT_W   = dst_pkg::BIT_W;
  localparam int unsigned IDX_W   = dst_pkg::IDX_W;
  localparam int unsigned SCAN_W  = dst_pkg::SCAN_W;
  localparam int unsigned GROUPS  = dst_pkg::GROUPS;
  localparam int unsigned SLICES  = dst_pkg::WORD_SLICES;
  localparam logic [dst_pkg::SEL_IDX_W:0] TE_LIMIT =
    (dst_pkg::SEL_IDX_W + 1)'(dst_pkg::TABLE_ENTRIES);

  // memories
  logic [MAP_W-1:0] map_mem  [dst_pkg::MAP_WORDS];
  logic [63:0]      desc_mem [dst_pkg::TABLE_ENTRIES];

  dst_pkg::state_e state_q, state_d;
  dst_pkg::kind_e  kind_q;
  logic [31:0]                     base_q;
  logic                            sel_ok_q;
  logic                            full_q;
  logic [dst_pkg::GROUP_W-1:0]     g_q;
  logic [WORD_W-1:0]               word_q;
  logic [BIT_W-1:0]                bit_q;
  logic [dst_pkg::SLICE_W-1:0]     slice_q;
  logic [dst_pkg::LIMIT_W-1:0]     tss_limit_q;
  logic [dst_pkg::MAP_WORDS-1:0]   used_full_q;
  logic [dst_pkg::MAP_WORDS-1:0]   map_valid_q;
  logic [dst_pkg::FRESH_N-1:0]     touched_q;
  logic [MAP_W-1:0]                map_rdata_q;
  logic [63:0]                     desc_rdata_q;
  logic                            out_valid_q;
  logic                            out_status_q;
  logic [15:0]                     out_sel_q;
  logic [63:0]                     out_word_q;

  logic                            accept;
  logic                            commit;
  logic [dst_pkg::SEL_IDX_W-1:0]   sel_idx;
  logic                            sel_in_range;
  logic [GROUPS*SCAN_W-1:0]        full_pad;
  logic [SCAN_W-1:0]               group_vec;
  logic [MAP_W-1:0]                eff_word;
  logic [SLICES*SCAN_W-1:0]        eff_pad;
  logic [SCAN_W-1:0]               ffz_in;
  dst_pkg::ffz_res_t               ffz_res;
  logic [dst_pkg::GROUP_W+dst_pkg::POS_W-1:0] word_wide;
  logic [dst_pkg::SLICE_W+dst_pkg::POS_W-1:0] bit_wide;
  logic [WORD_W-1:0]               word_pick;
  logic [BIT_W-1:0]                bit_pick;
  logic [IDX_W-1:0]                idx_cur;
  logic [MAP_W-1:0]                bit_mask;
  logic [MAP_W-1:0]                map_new;
  logic                            install_ok;
  logic                            uninst_ok;
  logic                            fresh;
  logic                            map_we;
  logic                            desc_we;
  logic                            map_re;
  logic [WORD_W-1:0]               map_raddr;
  logic                            desc_re;
  logic                            res_status;
  logic [15:0]                     res_sel;
  logic [63:0]                     res_word;

  assign in_i.ready = (state_q == dst_pkg::ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign commit     = (state_q == dst_pkg::ST_DONE) && (!out_valid_q || out_o.ready);

  assign sel_idx      = in_i.selector[15:3];
  assign sel_in_range = ({1'b0, sel_idx} < TE_LIMIT);

  // summary vectors, padding reads as used
  always_comb begin
    full_pad = '1;
    full_pad[dst_pkg::MAP_WORDS-1:0] = used_full_q;
    group_vec = '1;
    for (int unsigned k = 0; k < GROUPS; k++) begin
      group_vec[k] = &full_pad[k*SCAN_W +: SCAN_W];
    end
  end

  assign eff_word = map_valid_q[word_q] ? map_rdata_q : dst_pkg::reset_word(word_q);

  always_comb begin
    eff_pad = '1;
    eff_pad[MAP_W-1:0] = eff_word;
  end

  always_comb begin
    unique case (state_q)
      dst_pkg::ST_GROUP: ffz_in = group_vec;
      dst_pkg::ST_WORD:  ffz_in = full_pad[g_q*SCAN_W +: SCAN_W];
      dst_pkg::ST_BITS:  ffz_in = eff_pad[slice_q*SCAN_W +: SCAN_W];
      default:           ffz_in = '1;
    endcase
  end

  dst_ffz u_ffz (
    .bits_i (ffz_in),
    .res_o  (ffz_res)
  );

  assign word_wide = {g_q, ffz_res.pos};
  assign bit_wide  = {slice_q, ffz_res.pos};
  assign word_pick = word_wide[WORD_W-1:0];
  assign bit_pick  = bit_wide[BIT_W-1:0];
  assign idx_cur   = {word_q, bit_q};
  assign bit_mask  = MAP_W'(1) << bit_q;

  assign install_ok = (kind_q == dst_pkg::KIND_INSTALL) && !full_q;
  assign uninst_ok  = (kind_q == dst_pkg::KIND_UNINSTALL) && sel_ok_q;
  assign map_new    = install_ok ? (eff_word | bit_mask) : (eff_word & ~bit_mask);
  assign map_we     = commit && (install_ok || uninst_ok);
  assign desc_we    = commit && install_ok;
  assign fresh      = (idx_cur < IDX_W'(dst_pkg::FRESH_N)) &&
                      !touched_q[idx_cur[dst_pkg::FRESH_W-1:0]];

  // response fields
  always_comb begin
    res_status = 1'b0;
    res_sel    = '0;
    res_word   = '0;
    unique case (kind_q)
      dst_pkg::KIND_INSTALL: begin
        res_status = full_q;
        if (!full_q) begin
          res_sel = 16'({idx_cur, 3'b000});
        end
      end
      dst_pkg::KIND_UNINSTALL: begin
        res_status = !sel_ok_q;
      end
      dst_pkg::KIND_LOOKUP: begin
        res_status = !sel_ok_q;
        if (sel_ok_q) begin
          if (fresh) begin
            res_word = dst_pkg::flat_word(idx_cur[dst_pkg::FRESH_W-1:0]);
          end else if (eff_word[bit_q]) begin
            res_word = desc_rdata_q;
          end
        end
      end
      dst_pkg::KIND_NONE: begin
        res_status = 1'b0;
      end
      default: begin
        res_status = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dst_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (dst_pkg::kind_e'(in_i.kind))
            dst_pkg::KIND_INSTALL:   state_d = dst_pkg::ST_GROUP;
            dst_pkg::KIND_UNINSTALL,
            dst_pkg::KIND_LOOKUP:    state_d = sel_in_range ? dst_pkg::ST_READ
                                                            : dst_pkg::ST_DONE;
            default:                 state_d = dst_pkg::ST_DONE;
          endcase
        end
      end
      dst_pkg::ST_GROUP: state_d = ffz_res.found ? dst_pkg::ST_WORD : dst_pkg::ST_DONE;
      dst_pkg::ST_WORD:  state_d = dst_pkg::ST_BITS;
      dst_pkg::ST_BITS:  state_d = ffz_res.found ? dst_pkg::ST_DONE : dst_pkg::ST_BITS;
      dst_pkg::ST_READ:  state_d = dst_pkg::ST_DONE;
      dst_pkg::ST_DONE:  state_d = commit ? dst_pkg::ST_IDLE : dst_pkg::ST_DONE;
      default:           state_d = dst_pkg::ST_IDLE;
    endcase
  end

  // memory read controls
  always_comb begin
    map_re    = 1'b0;
    map_raddr = word_q;
    desc_re   = 1'b0;
    unique case (state_q)
      dst_pkg::ST_WORD: begin
        map_re    = 1'b1;
        map_raddr = word_pick;
      end
      dst_pkg::ST_READ: begin
        map_re  = 1'b1;
        desc_re = 1'b1;
      end
      default: begin
        map_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dst_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      tss_limit_q <= dst_pkg::LIMIT_RESET;
      map_valid_q <= '0;
      touched_q   <= '0;
      for (int unsigned w = 0; w < dst_pkg::MAP_WORDS; w++) begin
        used_full_q[w] <= &dst_pkg::reset_word(WORD_W'(w));
      end
    end else begin
      state_q <= state_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        tss_limit_q <= cfg_wdata_i;
      end
      if (map_we) begin
        map_valid_q[word_q] <= 1'b1;
        used_full_q[word_q] <= install_ok && (&map_new);
        if (idx_cur < IDX_W'(dst_pkg::FRESH_N)) begin
          touched_q[idx_cur[dst_pkg::FRESH_W-1:0]] <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= dst_pkg::kind_e'(in_i.kind);
      base_q   <= in_i.base_address;
      sel_ok_q <= sel_in_range;
      word_q   <= sel_idx[IDX_W-1:BIT_W];
      bit_q    <= sel_idx[BIT_W-1:0];
      full_q   <= 1'b0;
      slice_q  <= '0;
    end
    unique case (state_q)
      dst_pkg::ST_GROUP: begin
        g_q    <= ffz_res.pos[dst_pkg::GROUP_W-1:0];
        full_q <= !ffz_res.found;
      end
      dst_pkg::ST_WORD: begin
        word_q <= word_pick;
      end
      dst_pkg::ST_BITS: begin
        if (ffz_res.found) begin
          bit_q <= bit_pick;
        end else begin
          slice_q <= slice_q + dst_pkg::SLICE_W'(1);
        end
      end
      default: begin
      end
    endcase
    if (commit) begin
      out_status_q <= res_status;
      out_sel_q    <= res_sel;
      out_word_q   <= res_word;
    end
  end

  // bitmap and descriptor memories
  always_ff @(posedge clk_i) begin
    if (map_re) begin
      map_rdata_q <= map_mem[map_raddr];
    end
    if (map_we) begin
      map_mem[word_q] <= map_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (desc_re) begin
      desc_rdata_q <= desc_mem[idx_cur];
    end
    if (desc_we) begin
      desc_mem[idx_cur] <= dst_pkg::pack_tss(base_q, tss_limit_q);
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = out_status_q;
  assign out_o.new_selector    = out_sel_q;
  assign out_o.descriptor_word = out_word_q;

`ifndef NO_ASSERTIONS
  // the bitmap word being searched must hold a free slot
  a_search_word_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dst_pkg::ST_BITS) |-> !(&eff_word))
    else $error("bitmap search entered a full word");

  // an allocated slot was free before the install
  a_alloc_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && install_ok) |-> !eff_word[bit_q])
    else $error("install allocated a slot that is already used");

  // a response beat only follows a commit of the sequencer
  a_resp_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == dst_pkg::ST_DONE))
    else $error("response beat without a finished request");

  // a full summary answer leaves the table untouched
  a_full_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dst_pkg::ST_GROUP && !ffz_res.found) |=> !map_we && !desc_we)
    else $error("full table install wrote state");
`endif

endmodule

`default_nettype wire
